/* hw/rtl/uvs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvs_pkg
// Shared types, constants and fixed-point helpers of the uv sphere generator.
// ----------------------------------------------------------------------------
package uvs_pkg;

   // field widths
   localparam int COL_W  = 9;
   localparam int DIVS_W = 9;
   localparam int RAD_W  = 16;
   localparam int FIX_W  = 16;
   localparam int TEX_W  = 17;
   localparam int IDX_W  = 17;
   localparam int CSR_W  = 16;

   // divisions
   localparam int            MAX_DIVISIONS_DEF = 256;
   localparam logic [DIVS_W-1:0] LON_MIN = 9'd3;
   localparam logic [DIVS_W-1:0] LAT_MIN = 9'd2;
   localparam logic [DIVS_W-1:0] LON_RESET = 9'd16;
   localparam logic [DIVS_W-1:0] LAT_RESET = 9'd8;
   localparam logic [RAD_W-1:0]  RADIUS_RESET = 16'd256;

   // queue and pipeline geometry
   localparam int QUEUE_DEPTH = 4;
   localparam int DIV_STEPS   = 17;
   localparam int NUM_W       = 26;
   localparam int SIN_LAT     = 5;
   localparam int SB_LEN      = DIV_STEPS + SIN_LAT + 2;

   // quarter-wave polynomial
   localparam logic [17:0] POLY_C1 = 18'd205887;
   localparam logic [16:0] POLY_C2 = 17'd84093;
   localparam logic [13:0] POLY_C3 = 14'd9278;
   localparam logic [15:0] QUARTER_TURN = 16'd16384;

   typedef enum logic {
      ACT_VERTEX = 1'b0,
      ACT_QUAD   = 1'b1
   } action_type;

   typedef enum logic [1:0] {
      CSR_LON    = 2'd0,
      CSR_LAT    = 2'd1,
      CSR_RADIUS = 2'd2
   } csr_index_type;

   // one accepted request with clamped divisions
   typedef struct packed {
      logic              action;
      logic [COL_W-1:0]  col;
      logic [COL_W-1:0]  row;
      logic [DIVS_W-1:0] lon;
      logic [DIVS_W-1:0] lat;
   } job_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } push_type;

   // control carried alongside the arithmetic pipeline
   typedef struct packed {
      logic              valid;
      logic              action;
      logic [IDX_W-1:0]  corner;
      logic [DIVS_W-1:0] lon;
   } sideband_type;

   typedef struct packed {
      logic [TEX_W-1:0] u;
      logic [TEX_W-1:0] v;
   } tex_type;

   // signed q1.14 product, rounded half away from zero
   function automatic logic signed [17:0] mul_round14(input logic signed [15:0] a,
                                                      input logic signed [15:0] b);
      logic signed [31:0] p;
      logic [31:0]        m;
      logic [17:0]        r;
      p = a * b;
      m = p[31] ? 32'(-p) : 32'(p);
      r = 18'((m + 32'd8192) >> 14);
      return p[31] ? -$signed(r) : $signed(r);
   endfunction

   function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
      if (v > 18'sd32767) begin
         return 16'sh7fff;
      end else if (v < -18'sd32768) begin
         return 16'sh8000;
      end
      return v[15:0];
   endfunction

endpackage

/* hw/rtl/uvs_req_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvs_req_if
// Request channel: action and grid point with valid/ready handshake.
// ----------------------------------------------------------------------------
interface uvs_req_if;
   import uvs_pkg::*;

   logic             valid;
   logic             ready;
   logic             action;
   logic [COL_W-1:0] grid_col;
   logic [COL_W-1:0] grid_row;

   modport source (output valid, action, grid_col, grid_row, input ready);
   modport sink   (input valid, action, grid_col, grid_row, output ready);
endinterface

/* hw/rtl/uvs_rsp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvs_rsp_if
// Response channel: vertex or triangle result with valid/ready handshake.
// ----------------------------------------------------------------------------
interface uvs_rsp_if;
   import uvs_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [FIX_W-1:0] pos_x;
   logic signed [FIX_W-1:0] pos_y;
   logic signed [FIX_W-1:0] pos_z;
   logic signed [FIX_W-1:0] norm_x;
   logic signed [FIX_W-1:0] norm_y;
   logic signed [FIX_W-1:0] norm_z;
   logic [TEX_W-1:0]        tex_u;
   logic [TEX_W-1:0]        tex_v;
   logic [IDX_W-1:0]        corner_first;
   logic [IDX_W-1:0]        corner_second;
   logic [IDX_W-1:0]        corner_third;
   logic                    last_of_run;

   modport source (output valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_u, tex_v,
                   corner_first, corner_second, corner_third, last_of_run, input ready);
   modport sink   (input valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_u, tex_v,
                   corner_first, corner_second, corner_third, last_of_run, output ready);
endinterface

/* hw/rtl/uvs_ram_unused_placeholder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvs_front
// Request intake: clamps the divisions, range-checks and classifies requests.
// ----------------------------------------------------------------------------
module uvs_front #(
   parameter int MAX_DIVISIONS = uvs_pkg::MAX_DIVISIONS_DEF
) (
   uvs_req_if.sink                      req,
   input  logic [uvs_pkg::DIVS_W-1:0]   lon_cfg,
   input  logic [uvs_pkg::DIVS_W-1:0]   lat_cfg,
   input  logic                         queue_ready,
   output uvs_pkg::push_type            push
);
   import uvs_pkg::*;

   logic [DIVS_W-1:0] lon;
   logic [DIVS_W-1:0] lat;
   logic              in_range;

   // clamp divisions to the legal range
   always_comb begin
      if (lon_cfg < LON_MIN) begin
         lon = LON_MIN;
      end else if (32'(lon_cfg) > MAX_DIVISIONS) begin
         lon = DIVS_W'(MAX_DIVISIONS);
      end else begin
         lon = lon_cfg;
      end
      if (lat_cfg < LAT_MIN) begin
         lat = LAT_MIN;
      end else if (32'(lat_cfg) > MAX_DIVISIONS) begin
         lat = DIVS_W'(MAX_DIVISIONS);
      end else begin
         lat = lat_cfg;
      end
   end

   // quads need a full cell, vertices may sit on the far edge
   always_comb begin
      if (req.action == ACT_QUAD) begin
         in_range = (req.grid_col < lon) && (req.grid_row < lat);
      end else begin
         in_range = (req.grid_col <= lon) && (req.grid_row <= lat);
      end
   end

   // out of range requests are consumed without a result
   assign req.ready       = queue_ready;
   assign push.valid      = req.valid && queue_ready && in_range;
   assign push.job.action = req.action;
   assign push.job.col    = req.grid_col;
   assign push.job.row    = req.grid_row;
   assign push.job.lon    = lon;
   assign push.job.lat    = lat;

endmodule

/* hw/rtl/uvs_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvs_queue
// Short request queue between intake and the arithmetic pipeline.
// ----------------------------------------------------------------------------
module uvs_queue (
   input  logic              clock,
   input  logic              reset,
   input  uvs_pkg::push_type push,
   output logic              push_ready,
   input  logic              pop,
   output logic              head_valid,
   output uvs_pkg::job_type  head
);
   import uvs_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   job_type           mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign push_ready = count_ff < CNT_W'(QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head       = mem_ff[rd_ptr_ff];

   // pointer and fill count
   always_comb begin
      wr_ptr_in = push.valid ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push.valid) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push.valid) begin
         mem_ff[wr_ptr_ff] <= push.job;
      end
   end

`ifndef SYNTH
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> (count_ff < CNT_W'(QUEUE_DEPTH)) || pop)
      else $error("request pushed into a full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("request popped from an empty queue");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (push.valid && !pop) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count did not follow a push");
`endif

endmodule

/* hw/rtl/uvs_divider.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvs_divider
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module uvs_divider (
   input  logic                        clock,
   input  logic                        enable,
   input  logic [uvs_pkg::NUM_W-1:0]   num,
   input  logic [uvs_pkg::DIVS_W-1:0]  den,
   output logic [uvs_pkg::TEX_W-1:0]   quo
);
   import uvs_pkg::*;

   logic [NUM_W-1:0]  rem_ff [DIV_STEPS];
   logic [DIVS_W-1:0] den_ff [DIV_STEPS];
   logic [TEX_W-1:0]  quo_ff [DIV_STEPS];
   logic [NUM_W-1:0]  rem_in [DIV_STEPS];
   logic [TEX_W-1:0]  quo_in [DIV_STEPS];
   logic [DIVS_W-1:0] den_in [DIV_STEPS];

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
      logic [NUM_W-1:0] rem_prev;
      logic [TEX_W-1:0] quo_prev;
      logic [NUM_W-1:0] shifted;
      logic             fits;

      // first stage takes the dividend, later stages the previous remainder
      if (k == 0) begin : g_first
         assign rem_prev  = num;
         assign quo_prev  = '0;
         assign den_in[k] = den;
      end else begin : g_next
         assign rem_prev  = rem_ff[k-1];
         assign quo_prev  = quo_ff[k-1];
         assign den_in[k] = den_ff[k-1];
      end

      // one compare and subtract for quotient bit DIV_STEPS-1-k
      always_comb begin
         shifted   = NUM_W'(den_in[k]) << (DIV_STEPS - 1 - k);
         fits      = rem_prev >= shifted;
         rem_in[k] = fits ? rem_prev - shifted : rem_prev;
         quo_in[k] = quo_prev | (TEX_W'(fits) << (DIV_STEPS - 1 - k));
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[k] <= rem_in[k];
            quo_ff[k] <= quo_in[k];
            den_ff[k] <= den_in[k];
         end
      end
   end

   assign quo = quo_ff[DIV_STEPS-1];

endmodule

/* hw/rtl/uvs_sine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvs_sine
// Five-stage fixed-point sine of a q0.16 turn, result in q1.14.
// ----------------------------------------------------------------------------
module uvs_sine (
   input  logic                              clock,
   input  logic                              enable,
   input  logic [15:0]                       angle,
   output logic signed [uvs_pkg::FIX_W-1:0]  value
);
   import uvs_pkg::*;

   logic [14:0] x1_ff, x2_ff, x3_ff, x4_ff;
   logic        neg1_ff, neg2_ff, neg3_ff, neg4_ff;
   logic [14:0] z2_ff, z3_ff;
   logic [16:0] t1_ff;
   logic [17:0] t2_ff;
   logic signed [FIX_W-1:0] value_ff;

   logic [14:0] x1_in;
   logic [29:0] sq;
   logic [28:0] p3;
   logic [31:0] p4;
   logic [33:0] p5;
   logic [14:0] s5;

   // quadrant fold and the polynomial products
   always_comb begin
      x1_in = angle[14] ? 15'(QUARTER_TURN) - {1'b0, angle[13:0]} : {1'b0, angle[13:0]};
      sq    = 30'(x1_ff) * 30'(x1_ff);
      p3    = 29'(z2_ff) * 29'(POLY_C3);
      p4    = 32'(z3_ff) * 32'(t1_ff);
      p5    = 34'(x4_ff) * 34'(t2_ff) + 34'd65536;
      s5    = p5[31:17];
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         x1_ff    <= x1_in;
         neg1_ff  <= angle[15];
         z2_ff    <= sq[28:14];
         x2_ff    <= x1_ff;
         neg2_ff  <= neg1_ff;
         t1_ff    <= POLY_C2 - 17'(p3 >> 14);
         z3_ff    <= z2_ff;
         x3_ff    <= x2_ff;
         neg3_ff  <= neg2_ff;
         t2_ff    <= POLY_C1 - 18'(p4 >> 14);
         x4_ff    <= x3_ff;
         neg4_ff  <= neg3_ff;
         value_ff <= neg4_ff ? -$signed({1'b0, s5}) : $signed({1'b0, s5});
      end
   end

   assign value = value_ff;

endmodule

/* hw/rtl/uvs_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvs_back
// Arithmetic pipeline: angle division, sine, normal and position products,
// and the result register that splits a quad into two triangles.
// ----------------------------------------------------------------------------
module uvs_back (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             head_valid,
   input  uvs_pkg::job_type                 head,
   output logic                             pop,
   input  logic signed [uvs_pkg::RAD_W-1:0] radius,
   uvs_rsp_if.source                        rsp
);
   import uvs_pkg::*;

   logic         adv;
   logic         e_valid_ff;
   job_type      e_job_ff;
   sideband_type sb_ff [SB_LEN];
   sideband_type sb_head;
   tex_type      tx_ff [SIN_LAT+2];

   logic [NUM_W-1:0] num_u, num_v, num_p;
   logic [TEX_W-1:0] quo_u, quo_v, quo_p;
   logic signed [FIX_W-1:0] sin_phi, cos_phi, sin_th, cos_th;
   logic signed [FIX_W-1:0] nx_ff, ny_ff, nz_ff;
   logic signed [FIX_W-1:0] nx2_ff, ny2_ff, nz2_ff;
   logic signed [FIX_W-1:0] px_ff, py_ff, pz_ff;
   logic [IDX_W:0]   corner_full;

   logic                    out_valid_ff;
   logic                    out_last_ff;
   logic signed [FIX_W-1:0] out_px_ff, out_py_ff, out_pz_ff;
   logic signed [FIX_W-1:0] out_nx_ff, out_ny_ff, out_nz_ff;
   logic [TEX_W-1:0]        out_u_ff, out_v_ff;
   logic [IDX_W-1:0]        out_c1_ff, out_c2_ff, out_c3_ff;
   logic                    rsp_fire;

   // pipeline moves whenever the result register is free or being emptied
   assign adv      = !out_valid_ff || (rsp.ready && out_last_ff);
   assign pop      = adv && head_valid;
   assign rsp_fire = out_valid_ff && rsp.ready;

   // entry stage
   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else if (adv) begin
         e_valid_ff <= head_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         e_job_ff <= head;
      end
   end

   // rounded angle dividends
   always_comb begin
      num_u = NUM_W'({e_job_ff.col, 16'd0}) + NUM_W'(e_job_ff.lon >> 1);
      num_v = NUM_W'({e_job_ff.row, 16'd0}) + NUM_W'(e_job_ff.lat >> 1);
      num_p = NUM_W'({e_job_ff.row, 15'd0}) + NUM_W'(e_job_ff.lat >> 1);
      corner_full = (IDX_W+1)'(e_job_ff.row) * (IDX_W+1)'({1'b0, e_job_ff.lon} + 10'd1)
                    + (IDX_W+1)'(e_job_ff.col);
   end

   uvs_divider u_div_u (.clock, .enable(adv), .num(num_u), .den(e_job_ff.lon), .quo(quo_u));
   uvs_divider u_div_v (.clock, .enable(adv), .num(num_v), .den(e_job_ff.lat), .quo(quo_v));
   uvs_divider u_div_p (.clock, .enable(adv), .num(num_p), .den(e_job_ff.lat), .quo(quo_p));

   uvs_sine u_sin_phi (.clock, .enable(adv), .angle(quo_p[15:0]), .value(sin_phi));
   uvs_sine u_cos_phi (.clock, .enable(adv), .angle(quo_p[15:0] + QUARTER_TURN),
                       .value(cos_phi));
   uvs_sine u_sin_th  (.clock, .enable(adv), .angle(quo_u[15:0]), .value(sin_th));
   uvs_sine u_cos_th  (.clock, .enable(adv), .angle(quo_u[15:0] + QUARTER_TURN),
                       .value(cos_th));

   // control sideband and texture coordinates, aligned with the arithmetic
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SB_LEN; i++) begin
            sb_ff[i].valid <= 1'b0;
         end
      end else if (adv) begin
         sb_ff[0].valid  <= e_valid_ff;
         sb_ff[0].action <= e_job_ff.action;
         sb_ff[0].corner <= corner_full[IDX_W-1:0];
         sb_ff[0].lon    <= e_job_ff.lon;
         for (int i = 1; i < SB_LEN; i++) begin
            sb_ff[i] <= sb_ff[i-1];
         end
         tx_ff[0].u <= quo_u;
         tx_ff[0].v <= quo_v;
         for (int i = 1; i < SIN_LAT + 2; i++) begin
            tx_ff[i] <= tx_ff[i-1];
         end
      end
   end

   assign sb_head = sb_ff[SB_LEN-1];

   // normal and position products
   always_ff @(posedge clock) begin
      if (adv) begin
         nx_ff  <= FIX_W'(mul_round14(sin_phi, cos_th));
         ny_ff  <= cos_phi;
         nz_ff  <= FIX_W'(mul_round14(sin_phi, sin_th));
         px_ff  <= sat16(mul_round14(nx_ff, radius));
         py_ff  <= sat16(mul_round14(ny_ff, radius));
         pz_ff  <= sat16(mul_round14(nz_ff, radius));
         nx2_ff <= nx_ff;
         ny2_ff <= ny_ff;
         nz2_ff <= nz_ff;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= sb_head.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         if (sb_head.action == ACT_QUAD) begin
            out_px_ff   <= '0;
            out_py_ff   <= '0;
            out_pz_ff   <= '0;
            out_nx_ff   <= '0;
            out_ny_ff   <= '0;
            out_nz_ff   <= '0;
            out_u_ff    <= '0;
            out_v_ff    <= '0;
            out_c1_ff   <= sb_head.corner;
            out_c2_ff   <= sb_head.corner + 1'b1;
            out_c3_ff   <= sb_head.corner + IDX_W'(sb_head.lon) + 1'b1;
            out_last_ff <= 1'b0;
         end else begin
            out_px_ff   <= px_ff;
            out_py_ff   <= py_ff;
            out_pz_ff   <= pz_ff;
            out_nx_ff   <= nx2_ff;
            out_ny_ff   <= ny2_ff;
            out_nz_ff   <= nz2_ff;
            out_u_ff    <= tx_ff[SIN_LAT+1].u;
            out_v_ff    <= tx_ff[SIN_LAT+1].v;
            out_c1_ff   <= '0;
            out_c2_ff   <= '0;
            out_c3_ff   <= '0;
            out_last_ff <= 1'b1;
         end
      end else if (rsp_fire && !out_last_ff) begin
         // second triangle (b, d, c)
         out_c1_ff   <= out_c2_ff;
         out_c2_ff   <= out_c3_ff + 1'b1;
         out_last_ff <= 1'b1;
      end
   end

   assign rsp.valid         = out_valid_ff;
   assign rsp.pos_x         = out_px_ff;
   assign rsp.pos_y         = out_py_ff;
   assign rsp.pos_z         = out_pz_ff;
   assign rsp.norm_x        = out_nx_ff;
   assign rsp.norm_y        = out_ny_ff;
   assign rsp.norm_z        = out_nz_ff;
   assign rsp.tex_u         = out_u_ff;
   assign rsp.tex_v         = out_v_ff;
   assign rsp.corner_first  = out_c1_ff;
   assign rsp.corner_second = out_c2_ff;
   assign rsp.corner_third  = out_c3_ff;
   assign rsp.last_of_run   = out_last_ff;

`ifndef SYNTH
   a_quad_second: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && !out_last_ff) |=> out_valid_ff && out_last_ff
         && out_c1_ff == $past(out_c2_ff) && out_c3_ff == $past(out_c3_ff))
      else $error("second triangle of a quad not formed from the first");
   a_freeze: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(e_valid_ff) && $stable(sb_head.valid))
      else $error("pipeline moved while the result register was held");
   a_first_tri_blank: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_last_ff) |-> out_nx_ff == '0 && out_ny_ff == '0
         && out_u_ff == '0 && out_px_ff == '0)
      else $error("triangle result carries vertex data");
`endif

endmodule

/* hw/rtl/uv_sphere_mesh_generator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uv_sphere_mesh_generator
// Vertex and quad-triangle generator for a uv sphere in fixed point.
// ----------------------------------------------------------------------------
// Takes one request per clock while the result register is not held. A vertex
// request returns one result through a 4-entry request queue, an entry stage,
// 17 stages of restoring division for the angles and texture coordinates,
// 5 stages of polynomial sine, one stage of normal products, one of position
// products and the result register. A quad request returns two triangle
// results one after the other on the single result port, which holds the
// pipeline until the first triangle is taken. Out of range requests are consumed
// and return nothing. Divisions and radius are written over the csr port and
// must only change while the block is idle.
// ----------------------------------------------------------------------------
module uv_sphere_mesh_generator #(
   parameter int MAX_DIVISIONS = uvs_pkg::MAX_DIVISIONS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   uvs_req_if.sink                     req_stream,
   uvs_rsp_if.source                   rsp_stream,
   input  logic                        csr_we,
   input  logic [1:0]                  csr_index,
   input  logic [uvs_pkg::CSR_W-1:0]   csr_wdata
);
   import uvs_pkg::*;

   logic [DIVS_W-1:0]       lon_cfg_ff;
   logic [DIVS_W-1:0]       lat_cfg_ff;
   logic signed [RAD_W-1:0] radius_ff;
   push_type                push;
   logic                    queue_ready;
   logic                    head_valid;
   job_type                 head;
   logic                    pop;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         lon_cfg_ff <= LON_RESET;
         lat_cfg_ff <= LAT_RESET;
         radius_ff  <= RADIUS_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_LON:    lon_cfg_ff <= csr_wdata[DIVS_W-1:0];
            CSR_LAT:    lat_cfg_ff <= csr_wdata[DIVS_W-1:0];
            CSR_RADIUS: radius_ff  <= csr_wdata[RAD_W-1:0];
            default:    ;
         endcase
      end
   end

   uvs_front #(.MAX_DIVISIONS(MAX_DIVISIONS)) u_front (
      .req         (req_stream),
      .lon_cfg     (lon_cfg_ff),
      .lat_cfg     (lat_cfg_ff),
      .queue_ready (queue_ready),
      .push        (push)
   );

   uvs_queue u_queue (
      .clock,
      .reset,
      .push,
      .push_ready (queue_ready),
      .pop,
      .head_valid,
      .head
   );

   uvs_back u_back (
      .clock,
      .reset,
      .head_valid,
      .head,
      .pop,
      .radius (radius_ff),
      .rsp    (rsp_stream)
   );

endmodule
